// File: design/stgw_pkg.sv
// Shared types and constants for the styled text grid writer.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package stgw_pkg;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 9;
  localparam int unsigned EntryW    = 10;

  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharEscape  = 8'h00;

  typedef enum logic [CfgIndexW-1:0] {
    REG_DEF_TEXT = 3'd0,
    REG_DEF_BG   = 3'd1,
    REG_DEF_UL   = 3'd2,
    REG_COLUMNS  = 3'd3,
    REG_ROWS     = 3'd4,
    REG_CODE     = 3'd5
  } reg_index_t;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_WRITE    = 2'd1,
    KIND_BAD_CODE = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_CODE   = 2'd1,
    PH_COLOR  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    TGT_TEXT = 2'd0,
    TGT_BG   = 2'd1,
    TGT_UL   = 2'd2,
    TGT_POP  = 2'd3
  } target_t;

  typedef struct packed {
    logic [7:0] def_text;
    logic [7:0] def_bg;
    logic [7:0] def_ul;
    logic [8:0] cols_lim;
    logic [8:0] rows_lim;
    logic [7:0] code_base;
  } cfg_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] column;
    logic [7:0] row;
    logic [7:0] character;
    logic [7:0] fg_color;
    logic [7:0] bg_color;
    logic [7:0] ul_color;
    logic       string_done;
  } result_t;

endpackage

// File: design/stgw_cfg_regs.sv
// Configuration register bank of the styled text grid writer.
// Depends on stgw_pkg for the register indexes and the cfg_t bundle.
`timescale 1ns / 1ps

module stgw_cfg_regs
  import stgw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_wdata,
  output cfg_t                 cfg
);

  logic [7:0] def_text_r, def_bg_r, def_ul_r, code_base_r;
  logic [8:0] columns_r, rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_text_r  <= 8'd0;
      def_bg_r    <= 8'd0;
      def_ul_r    <= 8'd0;
      columns_r   <= 9'd80;
      rows_r      <= 9'd25;
      code_base_r <= 8'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEF_TEXT: def_text_r  <= cfg_wdata[7:0];
        REG_DEF_BG:   def_bg_r    <= cfg_wdata[7:0];
        REG_DEF_UL:   def_ul_r    <= cfg_wdata[7:0];
        REG_COLUMNS:  columns_r   <= cfg_wdata;
        REG_ROWS:     rows_r      <= cfg_wdata;
        REG_CODE:     code_base_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Sizes of 256 and above all mean a full 256-cell span.
  always_comb begin
    cfg.def_text  = def_text_r;
    cfg.def_bg    = def_bg_r;
    cfg.def_ul    = def_ul_r;
    cfg.code_base = code_base_r;
    cfg.cols_lim  = columns_r[8] ? 9'd256 : columns_r;
    cfg.rows_lim  = rows_r[8] ? 9'd256 : rows_r;
  end

endmodule

// File: design/stgw_stack_mem.sv
// Saved-style stack memory: one write port, one registered read port.
// A write to the entry being read is forwarded. Depends on stgw_pkg.
`timescale 1ns / 1ps

module stgw_stack_mem
  import stgw_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned AW = $clog2(STACK_DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [EntryW-1:0] wr_data,
  input  logic [AW-1:0]     rd_addr,
  output logic [EntryW-1:0] top
);

  logic [EntryW-1:0] mem [STACK_DEPTH];
  logic [EntryW-1:0] rd_q_r;
  logic [EntryW-1:0] byp_data_r;
  logic              byp_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r     <= mem[rd_addr];
    byp_data_r <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else begin
      byp_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign top = byp_r ? byp_data_r : rd_q_r;

endmodule

// File: design/stgw_parser.sv
// Escape parser, colour state and cursor of the styled text grid writer.
// Drives the stack memory ports; depends on stgw_pkg.
`timescale 1ns / 1ps

module stgw_parser
  import stgw_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned AW = $clog2(STACK_DEPTH),
  parameter int unsigned CW = $clog2(STACK_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              accept,
  input  logic [7:0]        text_byte,
  input  logic              last_byte,
  input  logic [EntryW-1:0] top,
  output logic              push_en,
  output logic [AW-1:0]     push_addr,
  output logic [EntryW-1:0] push_data,
  output logic [AW-1:0]     rd_addr,
  output result_t           res
);

  phase_t     phase_r, phase_nxt;
  logic [1:0] pend_r, pend_nxt;
  logic [7:0] txt_r, txt_nxt, bg_r, bg_nxt, ul_r, ul_nxt;
  logic [8:0] col_r, col_nxt, row_r, row_nxt;
  logic [CW-1:0] count_r, count_nxt, count_sel, count_dec;
  logic       open_r, open_nxt;

  logic [7:0] eff_txt, eff_bg, eff_ul, rel, sel_color;
  logic       push;

  always_comb begin
    eff_txt = open_r ? txt_r : cfg.def_text;
    eff_bg  = open_r ? bg_r  : cfg.def_bg;
    eff_ul  = open_r ? ul_r  : cfg.def_ul;
    rel     = text_byte - cfg.code_base;
    unique case (rel[1:0])
      TGT_TEXT: sel_color = eff_txt;
      TGT_BG:   sel_color = eff_bg;
      default:  sel_color = eff_ul;
    endcase

    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    txt_nxt   = eff_txt;
    bg_nxt    = eff_bg;
    ul_nxt    = eff_ul;
    col_nxt   = col_r;
    row_nxt   = row_r;
    count_nxt = count_r;
    count_dec = count_r - CW'(1);
    open_nxt  = 1'b1;
    push      = 1'b0;

    res                  = '0;
    res.kind             = KIND_NONE;
    res.string_done      = last_byte;

    unique case (phase_r)
      PH_CODE: begin
        phase_nxt = PH_NORMAL;
        if (rel <= 8'd2) begin
          if (count_r < CW'(STACK_DEPTH)) begin
            push      = 1'b1;
            count_nxt = count_r + CW'(1);
          end else begin
            res.kind = KIND_OVERFLOW;
          end
          pend_nxt  = rel[1:0];
          phase_nxt = PH_COLOR;
        end else if (rel == 8'd3) begin
          if (count_r != '0) begin
            count_nxt = count_dec;
            unique case (top[9:8])
              TGT_TEXT: txt_nxt = top[7:0];
              TGT_BG:   bg_nxt  = top[7:0];
              default:  ul_nxt  = top[7:0];
            endcase
          end
        end else begin
          res.kind = KIND_BAD_CODE;
        end
      end
      PH_COLOR: begin
        phase_nxt = PH_NORMAL;
        unique case (pend_r)
          TGT_TEXT: txt_nxt = text_byte;
          TGT_BG:   bg_nxt  = text_byte;
          default:  ul_nxt  = text_byte;
        endcase
      end
      default: begin
        if (row_r < cfg.rows_lim) begin
          if (text_byte == CharNewline) begin
            row_nxt = row_r + 9'd1;
            col_nxt = 9'd0;
          end else if (text_byte == CharEscape && !last_byte) begin
            phase_nxt = PH_CODE;
          end else if (col_r < cfg.cols_lim) begin
            res.kind      = KIND_WRITE;
            res.column    = col_r[7:0];
            res.row       = row_r[7:0];
            res.character = text_byte;
            res.fg_color  = eff_txt;
            res.bg_color  = eff_bg;
            res.ul_color  = eff_ul;
            col_nxt       = col_r + 9'd1;
          end
        end
      end
    endcase

    // The end of a string drops any open escape and empties the stack.
    if (last_byte) begin
      phase_nxt = PH_NORMAL;
      pend_nxt  = TGT_TEXT;
      col_nxt   = 9'd0;
      row_nxt   = 9'd0;
      count_nxt = '0;
      open_nxt  = 1'b0;
    end

    count_sel = accept ? count_nxt : count_r;
  end

  assign push_en   = accept && push;
  assign push_addr = count_r[AW-1:0];
  assign push_data = {rel[1:0], sel_color};
  // Keep the read port pointed at the entry that will be on top next cycle.
  assign rd_addr   = AW'(count_sel - CW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_NORMAL;
      pend_r  <= TGT_TEXT;
      txt_r   <= 8'd0;
      bg_r    <= 8'd0;
      ul_r    <= 8'd0;
      col_r   <= 9'd0;
      row_r   <= 9'd0;
      count_r <= '0;
      open_r  <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
      txt_r   <= txt_nxt;
      bg_r    <= bg_nxt;
      ul_r    <= ul_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      count_r <= count_nxt;
      open_r  <= open_nxt;
    end
  end

endmodule

// File: design/styled_text_grid_writer.sv
// Top level of the styled text grid writer: config bank, parser, stack memory
// and the result register. Depends on stgw_pkg and the stgw_* modules.
`timescale 1ns / 1ps

// The block takes one text byte per clock cycle while in_stall is low and
// returns exactly one result request per byte, in the cycle after the byte
// is accepted. Every byte is decoded combinationally: the saved-style
// stack lives in a memory with one write port and a registered read port
// that always holds the current stack top and forwards a push to the entry
// being read, so a pop can follow a push directly. The result sits in one
// output register, and a new byte is taken whenever that register is empty
// or being emptied in the same cycle; in_stall rises only while a result
// waits under out_stall. The stack memory needs no clearing after reset,
// since only entries that were pushed are ever read. Configuration should
// be written only while no request is in flight.

module styled_text_grid_writer
  import stgw_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_text_byte,
  input  logic                 in_last_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_kind,
  output logic [7:0]           out_column,
  output logic [7:0]           out_row,
  output logic [7:0]           out_character,
  output logic [7:0]           out_text_color,
  output logic [7:0]           out_background_color,
  output logic [7:0]           out_underline_color,
  output logic                 out_string_done
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  cfg_t              cfg;
  result_t           res, res_r;
  logic              out_valid_r;
  logic              accept;
  logic              push_en;
  logic [AW-1:0]     push_addr, rd_addr;
  logic [EntryW-1:0] push_data, top;

  // A byte is taken whenever the result register is free this cycle.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  stgw_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  stgw_parser #(
    .STACK_DEPTH (STACK_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .accept    (accept),
    .text_byte (in_text_byte),
    .last_byte (in_last_byte),
    .top       (top),
    .push_en   (push_en),
    .push_addr (push_addr),
    .push_data (push_data),
    .rd_addr   (rd_addr),
    .res       (res)
  );

  stgw_stack_mem #(
    .STACK_DEPTH (STACK_DEPTH),
    .AW          (AW)
  ) u_stack (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push_en),
    .wr_addr (push_addr),
    .wr_data (push_data),
    .rd_addr (rd_addr),
    .top     (top)
  );

  // The result register holds its payload while the consumer stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_kind             = res_r.kind;
  assign out_column           = res_r.column;
  assign out_row              = res_r.row;
  assign out_character        = res_r.character;
  assign out_text_color       = res_r.fg_color;
  assign out_background_color = res_r.bg_color;
  assign out_underline_color  = res_r.ul_color;
  assign out_string_done      = res_r.string_done;

endmodule

// File: design/stgw_checker.sv
// Port-level checker for styled_text_grid_writer, bound to the top level.
// Depends on stgw_pkg for the result kind codes.
`timescale 1ns / 1ps

module stgw_checker
  import stgw_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_kind,
  input logic [7:0] out_column,
  input logic [7:0] out_row,
  input logic [7:0] out_character,
  input logic [7:0] out_text_color,
  input logic [7:0] out_background_color,
  input logic [7:0] out_underline_color,
  input logic       out_string_done
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_column)
      && $stable(out_row) && $stable(out_character) && $stable(out_string_done))
    else $error("stalled result changed");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted request produced no result");

  a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !(in_valid && !in_stall) |=> !out_valid)
    else $error("result appeared without a request");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the result register was free");

  a_cell_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_WRITE |-> out_column == 8'd0 && out_row == 8'd0
      && out_character == 8'd0 && out_text_color == 8'd0
      && out_background_color == 8'd0 && out_underline_color == 8'd0)
    else $error("cell fields set on a result that writes no cell");

endmodule

bind styled_text_grid_writer stgw_checker u_stgw_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_kind             (out_kind),
  .out_column           (out_column),
  .out_row              (out_row),
  .out_character        (out_character),
  .out_text_color       (out_text_color),
  .out_background_color (out_background_color),
  .out_underline_color  (out_underline_color),
  .out_string_done      (out_string_done)
);

// File: verif/styled_text_grid_checker.sv
// Checker for the styled text grid writer: predicts each result from the
// accepted bytes and register writes, and compares it with the block's output.
// Depends on stgw_pkg for the register indexes, result kinds and parse phases.
`timescale 1ns / 1ps

module styled_text_grid_checker
  import stgw_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_wdata,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [7:0]           in_text_byte,
  input  logic                 in_last_byte,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [1:0]           out_kind,
  input  logic [7:0]           out_column,
  input  logic [7:0]           out_row,
  input  logic [7:0]           out_character,
  input  logic [7:0]           out_text_color,
  input  logic [7:0]           out_background_color,
  input  logic [7:0]           out_underline_color,
  input  logic                 out_string_done,
  output int                   mismatches,
  output int                   results_owed,
  output int                   results_seen
);

  cfg_t              regs;
  phase_t            phase;
  target_t           color_target;
  logic [7:0]        cur_text;
  logic [7:0]        cur_bg;
  logic [7:0]        cur_ul;
  int unsigned       cur_col;
  int unsigned       cur_row;
  logic [EntryW-1:0] saved [STACK_DEPTH];
  int unsigned       depth_used;
  logic              string_open;
  result_t           cells_due[$];
  int                fail_total;
  int                seen_total;

  initial begin
    mismatches   = 0;
    results_owed = 0;
    results_seen = 0;
    fail_total   = 0;
    seen_total   = 0;
  end

  function automatic int unsigned grid_limit(logic [8:0] v);
    return (v > 9'd256) ? 256 : v;
  endfunction

  function automatic logic [7:0] color_of(target_t t);
    case (t)
      TGT_TEXT: return cur_text;
      TGT_BG:   return cur_bg;
      default:  return cur_ul;
    endcase
  endfunction

  task automatic set_color(target_t t, logic [7:0] c);
    case (t)
      TGT_TEXT: cur_text = c;
      TGT_BG:   cur_bg = c;
      default:  cur_ul = c;
    endcase
  endtask

  task automatic restart_string();
    phase        = PH_NORMAL;
    color_target = TGT_TEXT;
    cur_col      = 0;
    cur_row      = 0;
    depth_used   = 0;
    string_open  = 1'b0;
  endtask

  // Works out the result of one byte and moves the grid state on.
  task automatic predict_cell(input logic [7:0] ch, input logic fin, output result_t res);
    logic [7:0]        rel;
    logic [EntryW-1:0] entry;
    res             = '0;
    res.kind        = KIND_NONE;
    res.string_done = fin;
    if (!string_open) begin
      cur_text    = regs.def_text;
      cur_bg      = regs.def_bg;
      cur_ul      = regs.def_ul;
      string_open = 1'b1;
    end
    case (phase)
      PH_CODE: begin
        rel   = ch - regs.code_base;
        phase = PH_NORMAL;
        if (rel[7:2] != '0) begin
          res.kind = KIND_BAD_CODE;
        end else if (target_t'(rel[1:0]) == TGT_POP) begin
          if (depth_used > 0) begin
            depth_used--;
            entry = saved[depth_used];
            set_color(target_t'(entry[9:8]), entry[7:0]);
          end
        end else begin
          if (depth_used < STACK_DEPTH) begin
            saved[depth_used] = {rel[1:0], color_of(target_t'(rel[1:0]))};
            depth_used++;
          end else begin
            res.kind = KIND_OVERFLOW;
          end
          color_target = target_t'(rel[1:0]);
          phase        = PH_COLOR;
        end
      end
      PH_COLOR: begin
        set_color(color_target, ch);
        phase = PH_NORMAL;
      end
      default: begin
        if (cur_row < grid_limit(regs.rows_lim)) begin
          if (ch == CharNewline) begin
            cur_row++;
            cur_col = 0;
          end else if (ch == CharEscape && !fin) begin
            phase = PH_CODE;
          end else if (cur_col < grid_limit(regs.cols_lim)) begin
            res.kind      = KIND_WRITE;
            res.column    = cur_col[7:0];
            res.row       = cur_row[7:0];
            res.character = ch;
            res.fg_color  = cur_text;
            res.bg_color  = cur_bg;
            res.ul_color  = cur_ul;
            cur_col++;
          end
        end
      end
    endcase
    if (fin) begin
      restart_string();
      cur_text = regs.def_text;
      cur_bg   = regs.def_bg;
      cur_ul   = regs.def_ul;
    end
  endtask

  task automatic report_mismatch(string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    fail_total++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) begin
      report_mismatch($sformatf("result %0d: %s is %0d, predicted %0d",
                                seen_total, name, got, want));
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      regs.def_text  = '0;
      regs.def_bg    = '0;
      regs.def_ul    = '0;
      regs.cols_lim  = 9'd80;
      regs.rows_lim  = 9'd25;
      regs.code_base = 8'd1;
      cur_text       = '0;
      cur_bg         = '0;
      cur_ul         = '0;
      restart_string();
      cells_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen_total++;
        if (cells_due.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no byte waiting for it",
                                    seen_total));
        end else begin
          want = cells_due.pop_front();
          check_field("kind", out_kind, want.kind);
          check_field("column", out_column, want.column);
          check_field("row", out_row, want.row);
          check_field("character", out_character, want.character);
          check_field("text color", out_text_color, want.fg_color);
          check_field("background color", out_background_color, want.bg_color);
          check_field("underline color", out_underline_color, want.ul_color);
          check_field("string_done", out_string_done, want.string_done);
        end
      end
      if (in_valid && !in_stall) begin
        predict_cell(in_text_byte, in_last_byte, want);
        cells_due = {cells_due, want};
      end
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_DEF_TEXT: regs.def_text = cfg_wdata[7:0];
          REG_DEF_BG:   regs.def_bg = cfg_wdata[7:0];
          REG_DEF_UL:   regs.def_ul = cfg_wdata[7:0];
          REG_COLUMNS:  regs.cols_lim = cfg_wdata;
          REG_ROWS:     regs.rows_lim = cfg_wdata;
          REG_CODE:     regs.code_base = cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
    mismatches   <= fail_total;
    results_owed <= cells_due.size();
    results_seen <= seen_total;
  end

endmodule

// File: verif/tb_styled_text_grid_writer.sv
// Testbench top for the styled text grid writer: clock, reset, register
// settings, byte stimulus and the verdict. Depends on stgw_pkg, the block
// and styled_text_grid_checker.
`timescale 1ns / 1ps

module tb_styled_text_grid_writer
  import stgw_pkg::*;
();

  localparam int unsigned StackDepth  = 16;
  localparam time         ClkPeriod   = 10ns;
  localparam int unsigned DrainCycles = 4;
  // The slowest correct run finishes far inside this watchdog limit.
  localparam time         RunLimit    = 5ms;

  // The directed strings run with the code base at its reset value.
  localparam logic [7:0] DirBase   = 8'd1;
  localparam logic [7:0] DPushText = DirBase + 8'(TGT_TEXT);
  localparam logic [7:0] DPushBg   = DirBase + 8'(TGT_BG);
  localparam logic [7:0] DPushUl   = DirBase + 8'(TGT_UL);
  localparam logic [7:0] DPop      = DirBase + 8'(TGT_POP);
  localparam int unsigned DirCount = 26;

  // Each entry is {last byte marker, byte}. The grid is three columns by two rows.
  localparam logic [8:0] DirScript [DirCount] = '{
    // Plain write, push text with a new color, pop it back, pop on an empty
    // stack, fill the row and run past its width, then a zero code byte
    // (invalid), and a background push that is the last byte.
    {1'b0, 8'h41}, {1'b0, CharEscape}, {1'b0, DPushText}, {1'b0, 8'hFF},
    {1'b0, 8'h42}, {1'b0, CharEscape}, {1'b0, DPop}, {1'b0, CharEscape},
    {1'b0, DPop}, {1'b0, 8'h43}, {1'b0, 8'h44}, {1'b0, CharNewline},
    {1'b0, CharEscape}, {1'b0, CharEscape}, {1'b0, CharEscape}, {1'b1, DPushBg},
    // Underline push with a color, a write, then a zero that ends the string
    // and so is an ordinary character.
    {1'b0, CharEscape}, {1'b0, DPushUl}, {1'b0, 8'h80}, {1'b0, 8'h45},
    {1'b1, CharEscape},
    // Two newlines use up both rows; the escape and the rest write nothing.
    {1'b0, CharNewline}, {1'b0, CharNewline}, {1'b0, CharEscape}, {1'b0, DPushText},
    {1'b1, 8'h7A}
  };

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_text_byte = '0;
  logic                 in_last_byte = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_kind;
  logic [7:0]           out_column;
  logic [7:0]           out_row;
  logic [7:0]           out_character;
  logic [7:0]           out_text_color;
  logic [7:0]           out_background_color;
  logic [7:0]           out_underline_color;
  logic                 out_string_done;

  int                   mismatches;
  int                   results_owed;
  int                   results_seen;

  // Sender bookkeeping and the code base the random strings are built for.
  int unsigned          burst_left = 0;
  int unsigned          bytes_sent = 0;
  int unsigned          strings_sent = 0;
  int unsigned          settings_used = 0;
  logic [7:0]           code_base = DirBase;
  logic [7:0]           line_bytes[$];

  stall_mode_t          stall_mode = STALL_NONE;
  int unsigned          stall_left = 0;

  always #(ClkPeriod / 2) clk = ~clk;

  styled_text_grid_writer #(
    .STACK_DEPTH(StackDepth)
  ) uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_text_byte        (in_text_byte),
    .in_last_byte        (in_last_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_column          (out_column),
    .out_row             (out_row),
    .out_character       (out_character),
    .out_text_color      (out_text_color),
    .out_background_color(out_background_color),
    .out_underline_color (out_underline_color),
    .out_string_done     (out_string_done)
  );

  styled_text_grid_checker #(
    .STACK_DEPTH(StackDepth)
  ) grid_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_text_byte        (in_text_byte),
    .in_last_byte        (in_last_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_column          (out_column),
    .out_row             (out_row),
    .out_character       (out_character),
    .out_text_color      (out_text_color),
    .out_background_color(out_background_color),
    .out_underline_color (out_underline_color),
    .out_string_done     (out_string_done),
    .mismatches          (mismatches),
    .results_owed        (results_owed),
    .results_seen        (results_seen)
  );

  // The receiver switches at random between stall styles: no stalls at all,
  // occasional stalls, mostly stalled, and regular runs of stall cycles. This
  // puts back-pressure on every phase of an escape.
  always @(posedge clk) begin : stall_pattern
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(STALL_NONE, STALL_RUNS));
      stall_left <= $urandom_range(20, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= ((stall_left % 9) < 6);
    endcase
  end

  // Offers one byte and returns at the clock edge that accepts it. The sender
  // works in bursts; between bursts it may drop valid for a random gap. Valid
  // is only lowered at the start of a gap, so a byte that follows an accepted
  // one in the same burst keeps valid high without a glitch.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_text_byte <= b;
    in_last_byte <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Sends the composed string with the last marker on its final byte.
  task automatic send_line();
    foreach (line_bytes[i]) send_byte(line_bytes[i], i == line_bytes.size() - 1);
    strings_sent++;
  endtask

  // Stops sending and waits until every predicted result has been taken,
  // then waits out a drain period so nothing is still in flight. The first edge
  // lets the checker count a byte accepted at the edge this was called on.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Holds the write enable high across consecutive register writes; the
  // caller lowers it once after the last one.
  task automatic put_reg(input reg_index_t idx, input logic [CfgDataW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  // Writes every register. Only called while the block is idle.
  task automatic apply_settings(input logic [7:0] def_text, input logic [7:0] def_bg,
                                input logic [7:0] def_ul, input logic [8:0] cols,
                                input logic [8:0] rows, input logic [7:0] base);
    put_reg(REG_DEF_TEXT, {1'b0, def_text});
    put_reg(REG_DEF_BG, {1'b0, def_bg});
    put_reg(REG_DEF_UL, {1'b0, def_ul});
    put_reg(REG_COLUMNS, cols);
    put_reg(REG_ROWS, rows);
    put_reg(REG_CODE, {1'b0, base});
    cfg_we <= 1'b0;
    @(posedge clk);
    code_base = base;
    settings_used++;
  endtask

  task automatic add_byte(input logic [7:0] b);
    line_bytes = {line_bytes, b};
  endtask

  task automatic push_escape(input logic [7:0] code);
    add_byte(CharEscape);
    add_byte(code);
  endtask

  task automatic push_style(input target_t t);
    push_escape(code_base + 8'(t));
    add_byte(8'($urandom_range(0, 255)));
  endtask

  // Builds one string from well-formed pieces with random content: text,
  // newlines, pushes with their colors, pops, invalid codes and bursts of
  // pushes that can overflow the stack. About a quarter of the strings are cut
  // short at a random byte, which leaves escapes open at the end, and a few
  // pieces are plain noise.
  task automatic compose_string();
    int unsigned pieces;
    line_bytes.delete();
    pieces = $urandom_range(1, 14);
    repeat (pieces) begin
      case ($urandom_range(0, 15))
        0, 1, 2, 3, 4: add_byte(8'($urandom_range(1, 255)));
        5, 6:          add_byte(CharNewline);
        7, 8, 9:       push_style(target_t'($urandom_range(TGT_TEXT, TGT_UL)));
        10, 11:        push_escape(code_base + 8'(TGT_POP));
        12:            push_escape(code_base + 8'($urandom_range(4, 255)));
        13: begin
          repeat ($urandom_range(StackDepth - 2, StackDepth + 3)) begin
            push_style(target_t'($urandom_range(TGT_TEXT, TGT_UL)));
          end
        end
        14: begin
          repeat ($urandom_range(5, 40)) add_byte(8'($urandom_range(1, 255)));
        end
        default:       add_byte(8'($urandom_range(0, 255)));
      endcase
    end
    if ($urandom_range(0, 3) == 0) begin
      line_bytes = line_bytes[0 : $urandom_range(0, line_bytes.size() - 1)];
    end
  endtask

  task automatic run_strings(input int unsigned byte_goal);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < byte_goal) begin
      compose_string();
      send_line();
    end
  endtask

  initial begin : stimulus
    logic [8:0] cols;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed strings on a small grid with distinct default colors.
    apply_settings(8'h12, 8'h34, 8'h56, 9'd3, 9'd2, DirBase);
    for (int i = 0; i < DirCount; i++) send_byte(DirScript[i][7:0], DirScript[i][8]);
    strings_sent += 3;
    wait_drained();

    // Extremes: the largest grid with the highest code base, where pop is
    // code 255, and then a one-cell grid where push text is the zero byte.
    apply_settings(8'hFF, 8'hFF, 8'hFF, 9'd256, 9'd256, 8'd252);
    run_strings(45);
    wait_drained();
    apply_settings(8'h00, 8'h00, 8'h00, 9'd1, 9'd1, 8'd0);
    run_strings(35);
    wait_drained();

    // Random settings, mostly narrow and short grids so that rows fill up
    // and bytes run past the width often.
    repeat (6) begin
      cols = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(1, 256))
                                         : 9'($urandom_range(1, 8));
      apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), cols, 9'($urandom_range(1, 4)),
                     8'($urandom_range(0, 252)));
      run_strings(45);
      wait_drained();
    end

    $display("Covered %0d bytes in %0d strings under %0d register settings; %0d results checked.",
             bytes_sent, strings_sent, settings_used, results_seen);
    if (mismatches == 0 && results_owed == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results still owed.", mismatches, results_owed);
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #(RunLimit);
    $display("Run limit reached with %0d results still owed.", results_owed);
    $display("== FAIL ==");
    $finish;
  end

endmodule
